### sv/likelihood_field_splat_top_defines.svh
// assertion macros for the likelihood field splat block
// needs i_clk and i_rst_n in the scope that uses them
`ifndef LIKELIHOOD_FIELD_SPLAT_TOP_DEFINES_SVH
`define LIKELIHOOD_FIELD_SPLAT_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LFS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfs assertion failed");

// antecedent implies consequent in the next cycle
`define LFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfs assertion failed");

`endif

### sv/lfs_pkg.sv
// shared constants, types and the weight table of the likelihood field splat block
// no dependencies
package lfs_pkg;

    localparam int CELL_XW   = 7;
    localparam int VAL_W     = 15;
    localparam int RADIUS    = 8;
    localparam int GRID_SIDE = 128;

    localparam int RAD_SQ = RADIUS * RADIUS;
    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W = $clog2(CELLS);
    localparam int GX_W   = $clog2(GRID_SIDE);
    localparam int OFF_W  = $clog2(RADIUS + 1) + 1;
    localparam int CRD_W  = $clog2((2 ** CELL_XW) + RADIUS) + 1;
    localparam int D2_W   = $clog2(2 * RAD_SQ + 1);
    localparam int ROM_AW = (RAD_SQ > 1) ? $clog2(RAD_SQ) : 1;
    localparam int ROM_N  = 2 ** ROM_AW;

    localparam int WEIGHT_PEAK  = 25600;
    localparam int EXP_NUM      = 9;
    localparam int EXP_SHIFT    = 27;
    localparam int TAYLOR_TERMS = 24;
    localparam int SQUARINGS    = 3;

    localparam longint unsigned Q_ONE  = 64'd1 << 31;
    localparam longint unsigned Q_HALF = 64'd1 << 30;

    localparam logic REQ_SPLAT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef logic [CELL_W-1:0] t_cell_addr;
    typedef logic [VAL_W-1:0]  t_value;

    typedef struct packed {
        logic       active;
        logic       last;
        logic       hit;
        t_cell_addr addr;
        t_value     weight;
    } t_step;

    // 100*exp(-4.5*d2/r^2) in unsigned 7.8, computed in integer arithmetic
    function automatic t_value weight_of(input int unsigned d2);
        longint unsigned u;
        longint unsigned term;
        longint unsigned e;
        longint          s;
        u = (64'(d2) * 64'(EXP_NUM)) << EXP_SHIFT;
        u = (u + 64'(RAD_SQ / 2)) / 64'(RAD_SQ);
        term = Q_ONE;
        s = longint'(Q_ONE);
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = ((term * u) >> 31) / 64'(k);
            if (k[0]) begin
                s = s - longint'(term);
            end else begin
                s = s + longint'(term);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        e = 64'(s);
        if (e > Q_ONE) begin
            e = Q_ONE;
        end
        for (int i = 0; i < SQUARINGS; i++) begin
            e = (e * e + Q_HALF) >> 31;
        end
        return VAL_W'((64'(WEIGHT_PEAK) * e + Q_HALF) >> 31);
    endfunction

    function automatic logic [ROM_N*VAL_W-1:0] build_rom();
        logic [ROM_N*VAL_W-1:0] r;
        r = '0;
        for (int i = 0; i < ROM_N; i++) begin
            if (i < RAD_SQ) begin
                r[i*VAL_W +: VAL_W] = weight_of(i);
            end
        end
        return r;
    endfunction

    localparam logic [ROM_N*VAL_W-1:0] WEIGHT_ROM = build_rom();

    function automatic t_cell_addr cell_addr(input logic [GX_W-1:0] x,
                                             input logic [GX_W-1:0] y);
        return CELL_W'(y) * CELL_W'(GRID_SIDE) + CELL_W'(x);
    endfunction

endpackage

### sv/lfs_stream_if.sv
// request and response channels of the likelihood field splat block
// depends on lfs_pkg
interface lfs_req_if;
    import lfs_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [CELL_XW-1:0] cell_x;
    logic [CELL_XW-1:0] cell_y;

    modport source (output valid, req_type, cell_x, cell_y, input ready);
    modport sink   (input valid, req_type, cell_x, cell_y, output ready);
endinterface

interface lfs_rsp_if;
    import lfs_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] cell_value;
    logic             was_read;

    modport source (output valid, cell_value, was_read, input ready);
    modport sink   (input valid, cell_value, was_read, output ready);
endinterface

### sv/lfs_grid_ram.sv
// simple dual-port grid memory, one write and one registered read per cycle
// no dependencies
module lfs_grid_ram #(
    parameter int DEPTH = 16384,
    parameter int DW    = 15,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/lfs_sweep.sv
// walks the square around an obstacle cell, one cell per cycle
// depends on lfs_pkg for offsets, grid geometry and the weight table
module lfs_sweep (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lfs_pkg::CELL_XW-1:0] i_cell_x,
    input  logic [lfs_pkg::CELL_XW-1:0] i_cell_y,
    output lfs_pkg::t_step              o_step
);
    import lfs_pkg::*;

    localparam logic signed [OFF_W-1:0] OFF_LO = OFF_W'(-RADIUS);
    localparam logic signed [OFF_W-1:0] OFF_HI = OFF_W'(RADIUS);

    logic                    r_active;
    logic signed [OFF_W-1:0] r_dx;
    logic signed [OFF_W-1:0] r_dy;
    logic [CELL_XW-1:0]      r_cx;
    logic [CELL_XW-1:0]      r_cy;

    logic signed [2*OFF_W-1:0] sq_x;
    logic signed [2*OFF_W-1:0] sq_y;
    logic [D2_W-1:0]           d2;
    logic signed [CRD_W-1:0]   x;
    logic signed [CRD_W-1:0]   y;
    logic                      on_grid;
    logic                      in_disc;
    logic                      last;
    logic [ROM_AW-1:0]         rom_idx;

    always_comb begin
        sq_x    = r_dx * r_dx;
        sq_y    = r_dy * r_dy;
        d2      = D2_W'(unsigned'(sq_x)) + D2_W'(unsigned'(sq_y));
        x       = signed'(CRD_W'({1'b0, r_cx})) + CRD_W'(r_dx);
        y       = signed'(CRD_W'({1'b0, r_cy})) + CRD_W'(r_dy);
        on_grid = (int'(x) >= 0) && (int'(x) < GRID_SIDE)
               && (int'(y) >= 0) && (int'(y) < GRID_SIDE);
        in_disc = int'(d2) < RAD_SQ;
        last    = (r_dx == OFF_HI) && (r_dy == OFF_HI);
        rom_idx = ROM_AW'(d2);

        o_step.active = r_active;
        o_step.last   = r_active && last;
        o_step.hit    = r_active && on_grid && in_disc;
        o_step.addr   = cell_addr(GX_W'(unsigned'(x)), GX_W'(unsigned'(y)));
        o_step.weight = WEIGHT_ROM[int'(rom_idx)*VAL_W +: VAL_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_start) begin
            r_active <= 1'b1;
        end else if (r_active && last) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dx <= OFF_LO;
            r_dy <= OFF_LO;
            r_cx <= i_cell_x;
            r_cy <= i_cell_y;
        end else if (r_active) begin
            if (r_dx == OFF_HI) begin
                r_dx <= OFF_LO;
                r_dy <= r_dy + OFF_W'(1);
            end else begin
                r_dx <= r_dx + OFF_W'(1);
            end
        end
    end

endmodule

### sv/likelihood_field_splat_top.sv
// Likelihood field splat block. Every result waits in the result state until the
// output slot is free. In a splat the sweep visits one cell of the square per cycle,
// bound by the grid memory's single read and single write port, with the write of each
// cell's running maximum in the cycle after its read. One request is worked on at a
// time; a new one is taken while the previous result waits at the output. After reset
// the grid's GRID_SIDE^2 cells (16384) are cleared before the first request is taken.
// depends on lfs_pkg, lfs_stream_if, lfs_sweep, lfs_grid_ram and the defines header
`include "likelihood_field_splat_top_defines.svh"

module likelihood_field_splat_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lfs_req_if.sink        i_req,
    lfs_rsp_if.source      o_rsp
);
    import lfs_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SPLAT  = 4'b0100,
        ST_RESULT = 4'b1000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    t_cell_addr r_clr_addr;
    logic       r_is_read;
    logic       r_rd_on_grid;
    logic       r_p1_hit;
    t_cell_addr r_p1_addr;
    t_value     r_p1_weight;
    logic       r_out_valid;
    t_value     r_out_value;
    logic       r_out_read;

    t_step      step;
    logic       accept;
    logic       start;
    logic       load_out;
    logic       slot_free;
    logic       ram_we;
    t_cell_addr ram_waddr;
    t_value     ram_wdata;
    logic       ram_re;
    t_cell_addr ram_raddr;
    t_value     ram_rdata;
    logic       req_on_grid;

    lfs_sweep u_sweep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cell_x (i_req.cell_x),
        .i_cell_y (i_req.cell_y),
        .o_step   (step)
    );

    lfs_grid_ram #(
        .DEPTH (CELLS),
        .DW    (VAL_W)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign slot_free   = !r_out_valid || o_rsp.ready;
    assign req_on_grid = (32'(i_req.cell_x) < GRID_SIDE) && (32'(i_req.cell_y) < GRID_SIDE);

    always_comb begin
        n_state   = r_state;
        start     = 1'b0;
        load_out  = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = step.addr;
        ram_we    = r_p1_hit && (r_p1_weight > ram_rdata);
        ram_waddr = r_p1_addr;
        ram_wdata = r_p1_weight;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == CELL_W'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.req_type == REQ_READ) begin
                        ram_re    = req_on_grid;
                        ram_raddr = cell_addr(GX_W'(i_req.cell_x), GX_W'(i_req.cell_y));
                        n_state   = ST_RESULT;
                    end else begin
                        start   = 1'b1;
                        n_state = ST_SPLAT;
                    end
                end
            end
            ST_SPLAT: begin
                ram_re = step.hit;
                if (step.last) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_p1_hit    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_hit <= (r_state == ST_SPLAT) && step.hit;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + CELL_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_addr   <= step.addr;
        r_p1_weight <= step.weight;
        if (accept) begin
            r_is_read    <= (i_req.req_type == REQ_READ);
            r_rd_on_grid <= req_on_grid;
        end
        if (load_out) begin
            r_out_read  <= r_is_read;
            r_out_value <= (r_is_read && r_rd_on_grid) ? ram_rdata : '0;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cell_value = r_out_value;
    assign o_rsp.was_read   = r_out_read;

    // read and write of one cycle never meet on the same cell
    `LFS_ASSERT_SAME(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr)
    // the sweep runs only while a splat is in progress
    `LFS_ASSERT_SAME(a_sweep_in_splat, step.active, r_state == ST_SPLAT)
    // the last cell of the square hands over to the result beat
    `LFS_ASSERT_NEXT(a_splat_ends, (r_state == ST_SPLAT) && step.last, r_state == ST_RESULT)
    // a pending write-back is always the cell read in the cycle before
    `LFS_ASSERT_NEXT(a_wb_follows_read, (r_state == ST_SPLAT) && step.hit,
                     r_p1_hit && (r_p1_addr == $past(ram_raddr)))

endmodule

### dv/tb_top.sv
// testbench of the likelihood field splat block: splats and reads against a scoreboard
// holding a shadow grid of running-maximum weights; depends on lfs_pkg, lfs_stream_if and
// the block's top level
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lfs_pkg::*;

    localparam int TAYLOR_LEN   = 24;
    localparam int EXP_MUL      = 9;
    localparam int EXP_SH       = 27;
    localparam int SPLAT_CYCLES = (2 * RADIUS + 1) * (2 * RADIUS + 1) + 2;
    localparam int RANDOM_ITEMS = 1000;
    localparam int BURST_ITEMS  = 280;

    typedef struct {
        t_value value;
        logic   was_read;
    } t_rsp_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lfs_req_if req_if ();
    lfs_rsp_if rsp_if ();

    likelihood_field_splat_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_value    shadow_grid [CELLS];
    t_value    gauss_tab [RAD_SQ];
    t_rsp_beat expected_rsp [$];
    t_rsp_beat front_beat;

    int        error_count = 0;
    int        splat_count = 0;
    int        read_count  = 0;
    int        hit_reads   = 0;
    bit        req_gap_on  = 1'b1;
    bit        rsp_stall_on = 1'b1;

    logic [CELL_XW-1:0] recent_x [$];
    logic [CELL_XW-1:0] recent_y [$];

    // 100*exp(-4.5*d2/r^2) in unsigned 7.8, truncated series of exp(-t/8) squared three times
    function automatic t_value gauss_weight(input int unsigned d2);
        longint unsigned arg;
        longint unsigned term;
        longint unsigned e;
        longint          acc;
        arg  = (64'(d2) * 64'(EXP_MUL)) << EXP_SH;
        arg  = (arg + 64'(RAD_SQ / 2)) / 64'(RAD_SQ);
        term = 64'd1 << 31;
        acc  = longint'(term);
        for (int k = 1; k <= TAYLOR_LEN; k++) begin
            term = ((term * arg) >> 31) / 64'(k);
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        e = 64'(acc);
        if (e > (64'd1 << 31)) begin
            e = 64'd1 << 31;
        end
        for (int i = 0; i < 3; i++) begin
            e = (e * e + (64'd1 << 30)) >> 31;
        end
        return VAL_W'((64'(WEIGHT_PEAK) * e + (64'd1 << 30)) >> 31);
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // update the shadow grid for an accepted splat, look up an accepted read, and queue its result
    task automatic record_request(input logic req, input int cx, input int cy);
        t_rsp_beat beat;
        int        x;
        int        y;
        int        d2;
        int        idx;
        if (req == REQ_READ) begin
            beat.value    = '0;
            beat.was_read = 1'b1;
            if (cx < GRID_SIDE && cy < GRID_SIDE) begin
                beat.value = shadow_grid[cy * GRID_SIDE + cx];
            end
            read_count++;
            if (beat.value != '0) begin
                hit_reads++;
            end
        end else begin
            for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
                for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
                    x  = cx + dx;
                    y  = cy + dy;
                    d2 = dx * dx + dy * dy;
                    if (d2 < RAD_SQ && x >= 0 && y >= 0 && x < GRID_SIDE && y < GRID_SIDE) begin
                        idx = y * GRID_SIDE + x;
                        if (gauss_tab[d2] > shadow_grid[idx]) begin
                            shadow_grid[idx] = gauss_tab[d2];
                        end
                    end
                end
            end
            beat.value    = '0;
            beat.was_read = 1'b0;
            splat_count++;
        end
        expected_rsp.push_back(beat);
    endtask

    task automatic send_request(input logic req, input logic [CELL_XW-1:0] x,
                                input logic [CELL_XW-1:0] y);
        int gap;
        gap = req_gap_on ? idle_len() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_if.valid    <= 1'b1;
        req_if.req_type <= req;
        req_if.cell_x   <= x;
        req_if.cell_y   <= y;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        record_request(req, int'(x), int'(y));
    endtask

    function automatic logic [CELL_XW-1:0] random_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return CELL_XW'($urandom_range(0, 1));
        end
        if (r == 1) begin
            return CELL_XW'((2 ** CELL_XW) - 1 - $urandom_range(0, 1));
        end
        return CELL_XW'($urandom);
    endfunction

    task automatic send_random_request();
        int                 r;
        int                 pick;
        logic [CELL_XW-1:0] x;
        logic [CELL_XW-1:0] y;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            if (recent_x.size() != 0 && $urandom_range(0, 9) < 3) begin
                pick = $urandom_range(0, recent_x.size() - 1);
                x = recent_x[pick] + CELL_XW'($urandom_range(0, 2 * RADIUS) - RADIUS);
                y = recent_y[pick] + CELL_XW'($urandom_range(0, 2 * RADIUS) - RADIUS);
            end else begin
                x = random_coord();
                y = random_coord();
            end
            recent_x.push_back(x);
            recent_y.push_back(y);
            if (recent_x.size() > 8) begin
                void'(recent_x.pop_front());
                void'(recent_y.pop_front());
            end
            send_request(REQ_SPLAT, x, y);
        end else if (r < 85 && recent_x.size() != 0) begin
            pick = $urandom_range(0, recent_x.size() - 1);
            x = recent_x[pick] + CELL_XW'($urandom_range(0, 2 * RADIUS + 2) - RADIUS - 1);
            y = recent_y[pick] + CELL_XW'($urandom_range(0, 2 * RADIUS + 2) - RADIUS - 1);
            send_request(REQ_READ, x, y);
        end else begin
            send_request(REQ_READ, random_coord(), random_coord());
        end
    endtask

    // grid corners and edges: neighbours off the grid are skipped
    task automatic test_edge_splats();
        send_request(REQ_READ,  7'd0,   7'd0);
        send_request(REQ_SPLAT, 7'd0,   7'd0);
        send_request(REQ_READ,  7'd0,   7'd0);
        send_request(REQ_READ,  7'd7,   7'd0);
        send_request(REQ_READ,  7'd8,   7'd0);
        send_request(REQ_READ,  7'd5,   7'd5);
        send_request(REQ_READ,  7'd0,   7'd7);
        send_request(REQ_SPLAT, 7'd127, 7'd127);
        send_request(REQ_READ,  7'd127, 7'd127);
        send_request(REQ_READ,  7'd120, 7'd127);
        send_request(REQ_SPLAT, 7'd0,   7'd127);
        send_request(REQ_SPLAT, 7'd127, 7'd0);
        send_request(REQ_READ,  7'd127, 7'd0);
        send_request(REQ_READ,  7'd0,   7'd120);
    endtask

    // running maximum, equal weight and a weaker overlapping splat
    task automatic test_running_max();
        send_request(REQ_SPLAT, 7'd64, 7'd64);
        send_request(REQ_READ,  7'd64, 7'd64);
        send_request(REQ_SPLAT, 7'd64, 7'd64);
        send_request(REQ_READ,  7'd64, 7'd64);
        send_request(REQ_SPLAT, 7'd66, 7'd64);
        send_request(REQ_READ,  7'd64, 7'd64);
        send_request(REQ_READ,  7'd66, 7'd64);
        send_request(REQ_READ,  7'd65, 7'd64);
        send_request(REQ_READ,  7'd72, 7'd64);
        send_request(REQ_READ,  7'd74, 7'd64);
    endtask

    task automatic test_random_field();
        req_gap_on   = 1'b1;
        rsp_stall_on = 1'b1;
        repeat (RANDOM_ITEMS) begin
            send_random_request();
        end
    endtask

    task automatic test_back_to_back();
        req_gap_on   = 1'b0;
        rsp_stall_on = 1'b0;
        repeat (BURST_ITEMS) begin
            send_random_request();
        end
        req_gap_on   = 1'b1;
        rsp_stall_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp.size() == 0) begin
                $error("result beat with nothing expected: cell_value %0d was_read %0b",
                       rsp_if.cell_value, rsp_if.was_read);
                error_count++;
            end else begin
                front_beat = expected_rsp.pop_front();
                if (rsp_if.cell_value !== front_beat.value) begin
                    $error("cell_value: expected %0d, actual %0d",
                           front_beat.value, rsp_if.cell_value);
                    error_count++;
                end
                if (rsp_if.was_read !== front_beat.was_read) begin
                    $error("was_read: expected %0b, actual %0b",
                           front_beat.was_read, rsp_if.was_read);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int hold;
        int gap;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = $urandom_range(1, 12);
            repeat (hold) begin
                @(negedge i_clk);
                rsp_if.ready <= 1'b1;
            end
            if (rsp_stall_on) begin
                gap = idle_len();
                repeat (gap) begin
                    @(negedge i_clk);
                    rsp_if.ready <= 1'b0;
                end
            end
        end
    end

    initial begin
        #30ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int settle;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_SPLAT;
        req_if.cell_x   = '0;
        req_if.cell_y   = '0;
        for (int i = 0; i < CELLS; i++) begin
            shadow_grid[i] = '0;
        end
        for (int d2 = 0; d2 < RAD_SQ; d2++) begin
            gauss_tab[d2] = gauss_weight(d2);
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_splats();
        test_running_max();
        test_random_field();
        test_back_to_back();

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (expected_rsp.size() != 0) begin
            @(posedge i_clk);
        end
        settle = 2 * SPLAT_CYCLES;
        repeat (settle) @(posedge i_clk);

        $display("covered %0d splats and %0d reads, %0d of the reads hit a nonzero weight",
                 splat_count, read_count, hit_reads);
        if (error_count == 0 && expected_rsp.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/lfs_pkg.sv
sv/lfs_stream_if.sv
sv/lfs_grid_ram.sv
sv/lfs_sweep.sv
sv/likelihood_field_splat_top.sv
dv/tb_top.sv
